// ===== hw/rtl/tsfq_pkg.sv =====
// Shared types and constants for the two-stack FIFO queue.
`default_nettype none

package tsfq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_EMPTYQ = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_XFER_RD,
        S_XFER_WR,
        S_TOP_RD,
        S_TOP_WAIT,
        S_DONE
    } t_state;

    localparam logic [31:0] DATA_EMPTY = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic               queue_empty;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hw/rtl/tsfq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tsfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/two_stack_fifo_queue.sv =====
// Top level of the FIFO queue built from an inbound and an outbound stack.
//
// Input words carry an opcode (push, pop, peek, empty query) and a push value.
// A word is taken when i_in_valid is high and o_in_stall is low; the block then
// raises o_in_stall until that word's single result has been loaded into the
// output register. Results appear on o_out_word with o_out_valid and leave when
// i_out_stall is low; a stalled result holds, and the block waits in its final
// state until the output register is free.
//
// States passed from acceptance to the result, with a free output register:
//   push and empty query           straight to S_DONE
//   pop and peek on an empty queue S_TOP_RD, then S_DONE
//   pop and peek, no transfer      S_TOP_RD, S_TOP_WAIT, then S_DONE
//   pop and peek with a transfer   S_XFER_RD and S_XFER_WR per word moved, then S_TOP_RD, S_TOP_WAIT, S_DONE
// The next word is taken only once the block is back in S_IDLE. The transfer
// loop moves one word at a time, reading it in S_XFER_RD and writing it in
// S_XFER_WR, through the single read port of each stack RAM. Each word is moved
// once, from the inbound to the outbound stack.
// Reset empties both stacks by clearing their counts; the stack RAMs are not
// cleared, as only entries below the counts are ever read.
`default_nettype none

module two_stack_fifo_queue #(
    parameter int DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tsfq_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tsfq_pkg::t_out_word     o_out_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    tsfq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_in_cnt, r_out_cnt;
    logic [1:0]        r_op;
    logic [31:0]       r_data;
    tsfq_pkg::t_status r_status;
    logic              r_out_valid;
    tsfq_pkg::t_out_word r_out_word;

    logic          in_accept;
    logic          out_free;
    logic          in_full;
    logic [CW-1:0] in_top, out_top;

    logic          in_we, out_we;
    logic [AW-1:0] in_raddr, out_raddr;
    logic [31:0]   in_rdata, out_rdata;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_full   = (r_in_cnt == CNT_FULL);
    assign in_top    = r_in_cnt - 1'b1;
    assign out_top   = r_out_cnt - 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsfq_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_in_word.opcode == tsfq_pkg::OP_POP ||
                        i_in_word.opcode == tsfq_pkg::OP_PEEK) begin
                        if (r_out_cnt == '0 && r_in_cnt != '0) begin
                            n_state = tsfq_pkg::S_XFER_RD;
                        end else begin
                            n_state = tsfq_pkg::S_TOP_RD;
                        end
                    end else begin
                        n_state = tsfq_pkg::S_DONE;
                    end
                end
            end
            tsfq_pkg::S_XFER_RD: n_state = tsfq_pkg::S_XFER_WR;
            tsfq_pkg::S_XFER_WR: begin
                n_state = (r_in_cnt != '0) ? tsfq_pkg::S_XFER_RD : tsfq_pkg::S_TOP_RD;
            end
            tsfq_pkg::S_TOP_RD: begin
                n_state = (r_out_cnt == '0) ? tsfq_pkg::S_DONE : tsfq_pkg::S_TOP_WAIT;
            end
            tsfq_pkg::S_TOP_WAIT: n_state = tsfq_pkg::S_DONE;
            tsfq_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = tsfq_pkg::S_IDLE;
                end
            end
            default: n_state = tsfq_pkg::S_IDLE;
        endcase
    end

    // Handshake and RAM controls.
    always_comb begin
        o_in_stall = 1'b1;
        in_we      = 1'b0;
        out_we     = 1'b0;
        in_raddr   = in_top[AW-1:0];
        out_raddr  = out_top[AW-1:0];
        case (r_state)
            tsfq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                in_we      = i_in_valid && (i_in_word.opcode == tsfq_pkg::OP_PUSH) &&
                             !in_full;
            end
            tsfq_pkg::S_XFER_WR: out_we = 1'b1;
            default: ;
        endcase
    end

    tsfq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_inbound (
        .i_clk  (i_clk),
        .i_we   (in_we),
        .i_waddr(r_in_cnt[AW-1:0]),
        .i_wdata(i_in_word.push_value),
        .i_raddr(in_raddr),
        .o_rdata(in_rdata)
    );

    tsfq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_outbound (
        .i_clk  (i_clk),
        .i_we   (out_we),
        .i_waddr(r_out_cnt[AW-1:0]),
        .i_wdata(in_rdata),
        .i_raddr(out_raddr),
        .o_rdata(out_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsfq_pkg::S_IDLE;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_we) begin
                r_in_cnt <= r_in_cnt + 1'b1;
            end
            case (r_state)
                tsfq_pkg::S_XFER_RD: r_in_cnt  <= in_top;
                tsfq_pkg::S_XFER_WR: r_out_cnt <= r_out_cnt + 1'b1;
                tsfq_pkg::S_TOP_WAIT: begin
                    if (r_op == tsfq_pkg::OP_POP) begin
                        r_out_cnt <= out_top;
                    end
                end
                default: ;
            endcase
            if (r_state == tsfq_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result fields; these need no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tsfq_pkg::S_IDLE: begin
                if (in_accept) begin
                    r_op     <= i_in_word.opcode;
                    r_data   <= '0;
                    r_status <= (i_in_word.opcode == tsfq_pkg::OP_PUSH && in_full) ?
                                tsfq_pkg::ST_FULL : tsfq_pkg::ST_OK;
                end
            end
            tsfq_pkg::S_TOP_RD: begin
                if (r_out_cnt == '0) begin
                    r_data   <= tsfq_pkg::DATA_EMPTY;
                    r_status <= tsfq_pkg::ST_EMPTY;
                end
            end
            tsfq_pkg::S_TOP_WAIT: r_data <= out_rdata;
            tsfq_pkg::S_DONE: begin
                if (out_free) begin
                    r_out_word.data_out    <= r_data;
                    r_out_word.status      <= r_status;
                    r_out_word.queue_empty <= (r_in_cnt == '0) && (r_out_cnt == '0);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== hw/rtl/tsfq_checker.sv =====
// Port-level assertions for the two-stack FIFO queue, bound to its top level.
`default_nettype none

module tsfq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire tsfq_pkg::t_in_word  i_in_word,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire tsfq_pkg::t_out_word o_out_word
);

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed or vanished");

    // One word at a time: after an accepted word the block is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again straight after an accepted word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == tsfq_pkg::ST_OK ||
                         o_out_word.status == tsfq_pkg::ST_FULL ||
                         o_out_word.status == tsfq_pkg::ST_EMPTY))
        else $error("undefined status code on result word");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == tsfq_pkg::ST_EMPTY |->
        o_out_word.data_out == tsfq_pkg::DATA_EMPTY && o_out_word.queue_empty)
        else $error("empty result without all-ones data or empty flag");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == tsfq_pkg::ST_FULL |->
        o_out_word.data_out == 32'sd0 && !o_out_word.queue_empty)
        else $error("refused push reported with data or an empty queue");

endmodule

bind two_stack_fifo_queue tsfq_checker u_tsfq_checker (.*);

`default_nettype wire

// ===== tb/two_stack_fifo_queue_tb.sv =====
// Self-checking testbench for the two-stack FIFO queue: directed and random words.
`default_nettype none

module two_stack_fifo_queue_tb;

    localparam int DEPTH       = 128;
    localparam int RANDOM_WORDS = 1050;
    localparam int CYCLE_LIMIT = 400000;

    // Mirrors the queue with two SystemVerilog queues used as stacks and keeps
    // the replies that the block owes, oldest first.
    class queue_mirror #(int CAP = 128);
        logic [31:0]         inbound[$];
        logic [31:0]         outbound[$];
        tsfq_pkg::t_out_word owed_replies[$];
        int unsigned mismatches;
        int unsigned refused_pushes;
        int unsigned empty_reads;
        int unsigned refills;
        int unsigned largest_refill;

        function void take_command(tsfq_pkg::t_in_word w);
            tsfq_pkg::t_out_word r;
            r = '0;
            case (w.opcode)
                tsfq_pkg::OP_PUSH: begin
                    if (inbound.size() >= CAP) begin
                        r.status = tsfq_pkg::ST_FULL;
                        refused_pushes++;
                    end else begin
                        inbound.push_back(w.push_value);
                    end
                end
                tsfq_pkg::OP_POP, tsfq_pkg::OP_PEEK: begin
                    // The outbound stack is only refilled once it has run dry.
                    if (outbound.size() == 0 && inbound.size() != 0) begin
                        refills++;
                        if (inbound.size() > largest_refill)
                            largest_refill = inbound.size();
                        while (inbound.size() != 0)
                            outbound.push_back(inbound.pop_back());
                    end
                    if (outbound.size() == 0) begin
                        r.data_out = tsfq_pkg::DATA_EMPTY;
                        r.status   = tsfq_pkg::ST_EMPTY;
                        empty_reads++;
                    end else begin
                        r.data_out = outbound[$];
                        if (w.opcode == tsfq_pkg::OP_POP)
                            void'(outbound.pop_back());
                    end
                end
                tsfq_pkg::OP_EMPTYQ: ;
                default: ;
            endcase
            r.queue_empty = (inbound.size() == 0 && outbound.size() == 0);
            owed_replies.push_back(r);
        endfunction

        function void check_reply(tsfq_pkg::t_out_word got);
            tsfq_pkg::t_out_word want;
            if (owed_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected reply: data %h status %0d empty %0b",
                             got.data_out, got.status, got.queue_empty);
                return;
            end
            want = owed_replies.pop_front();
            if (got.data_out !== want.data_out || got.status !== want.status ||
                got.queue_empty !== want.queue_empty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                             want.data_out, want.status, want.queue_empty,
                             got.data_out, got.status, got.queue_empty);
            end
        endfunction

        function int unsigned waiting();
            return owed_replies.size();
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    tsfq_pkg::t_in_word  in_word     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    tsfq_pkg::t_out_word out_word;

    queue_mirror #(DEPTH) mirror;
    int unsigned words_sent;
    int unsigned burst_left;
    int unsigned cycles;
    logic        hold_off;
    int unsigned rx_mode;
    int unsigned rx_mode_left;
    int unsigned rx_phase;

    two_stack_fifo_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d replies outstanding",
                     cycles, mirror.waiting());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: checks each reply taken and stalls on a pattern that changes
    // from time to time, plus the long hold-off requested below.
    always @(posedge i_clk) begin
        logic stall;
        stall = 1'b0;
        if (i_rst_n && out_valid && !out_stall)
            mirror.check_reply(out_word);
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(10, 200);
        end else begin
            rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
            0: stall = 1'b0;
            1: stall = ($urandom_range(0, 7) == 0);
            2: stall = ($urandom_range(0, 1) == 1);
            default: stall = (rx_phase % 6) < 4;
        endcase
        out_stall <= hold_off || stall;
    end

    // Long hold-offs on the receiving side fill the block so that it stalls
    // its input while words keep being offered.
    initial begin
        hold_off = 1'b0;
        wait (words_sent >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
        wait (words_sent >= 750);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (250) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic tsfq_pkg::t_in_word make_word(tsfq_pkg::t_opcode op,
                                                     logic [31:0] value);
        tsfq_pkg::t_in_word w;
        w.opcode     = op;
        w.push_value = value;
        return w;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Modes: 0 mostly pushes, 1 mostly reads, 2 balanced, 3 uniform noise.
    function automatic tsfq_pkg::t_in_word random_word(int unsigned mode);
        int unsigned       r;
        int unsigned       push_pct;
        int unsigned       pop_pct;
        int unsigned       peek_pct;
        tsfq_pkg::t_opcode op;
        r = $urandom_range(0, 99);
        case (mode)
            0:       begin push_pct = 80; pop_pct = 10; peek_pct = 5;  end
            1:       begin push_pct = 15; pop_pct = 65; peek_pct = 15; end
            2:       begin push_pct = 45; pop_pct = 35; peek_pct = 12; end
            default: begin push_pct = 25; pop_pct = 25; peek_pct = 25; end
        endcase
        if (r < push_pct)
            op = tsfq_pkg::OP_PUSH;
        else if (r < push_pct + pop_pct)
            op = tsfq_pkg::OP_POP;
        else if (r < push_pct + pop_pct + peek_pct)
            op = tsfq_pkg::OP_PEEK;
        else
            op = tsfq_pkg::OP_EMPTYQ;
        return make_word(op, pick_value());
    endfunction

    // Offers one word and waits for it to be taken; the sender works in bursts
    // with idle gaps between them.
    task automatic offer(tsfq_pkg::t_in_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge i_clk);
        while (in_stall);
        mirror.take_command(w);
        words_sent++;
    endtask

    initial begin
        int unsigned seg_mode;
        int unsigned seg_left;
        int unsigned seg_index;
        mirror     = new();
        burst_left = $urandom_range(1, 16);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, extreme values, refill with and without a
        // waiting outbound stack, and peeks that leave the word in place.
        offer(make_word(tsfq_pkg::OP_EMPTYQ, 32'h0));
        offer(make_word(tsfq_pkg::OP_POP,    32'h0));
        offer(make_word(tsfq_pkg::OP_PEEK,   32'hFFFF_FFFF));
        offer(make_word(tsfq_pkg::OP_PUSH,   32'h7FFF_FFFF));
        offer(make_word(tsfq_pkg::OP_PUSH,   32'h8000_0000));
        offer(make_word(tsfq_pkg::OP_PUSH,   32'h0000_0000));
        offer(make_word(tsfq_pkg::OP_PUSH,   32'hFFFF_FFFF));
        offer(make_word(tsfq_pkg::OP_EMPTYQ, 32'h1234_5678));
        offer(make_word(tsfq_pkg::OP_PEEK,   32'h0));
        offer(make_word(tsfq_pkg::OP_PUSH,   32'h5555_5555));
        offer(make_word(tsfq_pkg::OP_POP,    32'hAAAA_AAAA));
        offer(make_word(tsfq_pkg::OP_PEEK,   32'h0));
        offer(make_word(tsfq_pkg::OP_POP,    32'h0));
        offer(make_word(tsfq_pkg::OP_POP,    32'h0));
        offer(make_word(tsfq_pkg::OP_POP,    32'h0));
        offer(make_word(tsfq_pkg::OP_POP,    32'h0));
        offer(make_word(tsfq_pkg::OP_POP,    32'h0));
        offer(make_word(tsfq_pkg::OP_PEEK,   32'hDEAD_BEEF));
        offer(make_word(tsfq_pkg::OP_PUSH,   32'hAAAA_AAAA));
        offer(make_word(tsfq_pkg::OP_POP,    32'h0));
        offer(make_word(tsfq_pkg::OP_EMPTYQ, 32'hFFFF_FFFF));

        // Random: the first segments fill the inbound stack past refusal and
        // then drain it through a full-size refill.
        seg_index = 0;
        seg_mode  = 0;
        seg_left  = 220;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (seg_left == 0) begin
                seg_index++;
                seg_mode = (seg_index == 1) ? 1 : $urandom_range(0, 3);
                seg_left = (seg_index == 1) ? 220 : $urandom_range(30, 250);
            end
            seg_left--;
            offer(random_word(seg_mode));
        end
        in_valid <= 1'b0;

        while (mirror.waiting() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d words: %0d refused pushes, %0d empty reads,",
                 words_sent, mirror.refused_pushes, mirror.empty_reads);
        $display("%0d refills (largest %0d), %0d mismatches, %0d replies outstanding.",
                 mirror.refills, mirror.largest_refill, mirror.mismatches,
                 mirror.waiting());
        if (mirror.mismatches == 0 && mirror.waiting() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
